>>> src/gport_pkg.sv
package gport_pkg;

	// Number of axis timers and button latches
	localparam int unsigned AXES = 4;
	localparam int unsigned AXIS_IDX_W = $clog2(AXES);
	localparam int unsigned CNT_W = 15;
	localparam int unsigned RES_W = 7;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned RES_CODES = 1 << RES_W;

	// Pulse length formula constants
	localparam longint unsigned AXIS_BASE = 64'd242;
	localparam longint unsigned AXIS_SLOPE = 64'd110;
	localparam longint unsigned CLOCK_NUM = 64'd1431818;
	localparam longint unsigned CLOCK_DEN = 64'd1000000;

	// Configuration register indexes
	localparam logic CFG_STICK_ONE_PRESENT = 1'b0;
	localparam logic CFG_STICK_TWO_PRESENT = 1'b1;

	typedef enum logic [1:0] {
		OP_TRIGGER = 2'd0,
		OP_READ    = 2'd1,
		OP_TICK    = 2'd2
	} op_t;

	typedef logic [CNT_W-1:0] pulse_table_t [RES_CODES];

	// Pulse length for every resistance code, built at elaboration
	function automatic pulse_table_t build_pulse_table();
		pulse_table_t t;
		longint unsigned v;
		for (int r = 0; r < RES_CODES; r++) begin
			v = (AXIS_BASE + AXIS_SLOPE * longint'(r)) * CLOCK_NUM;
			t[r] = CNT_W'(v / CLOCK_DEN);
		end
		return t;
	endfunction

	localparam pulse_table_t PULSE_TABLE = build_pulse_table();
	localparam logic [CNT_W-1:0] PULSE_MAX = PULSE_TABLE[RES_CODES-1];

	// Request payload as seen by the datapath
	typedef struct packed {
		logic [TICK_W-1:0] tick_count;
		logic [AXES-1:0][RES_W-1:0] res;
		logic [AXES-1:0] fire;
	} req_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic latch_buttons;
		logic load_axis;
		logic tick_axis;
		logic [AXIS_IDX_W-1:0] axis;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

>>> src/gport_req_if.sv
interface gport_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [15:0] tick_count;
	logic [6:0] stick_one_x;
	logic [6:0] stick_one_y;
	logic [6:0] stick_two_x;
	logic [6:0] stick_two_y;
	logic stick_one_fire_a;
	logic stick_one_fire_b;
	logic stick_two_fire_a;
	logic stick_two_fire_b;

	modport source (
		output valid, operation, tick_count, stick_one_x, stick_one_y, stick_two_x,
			stick_two_y, stick_one_fire_a, stick_one_fire_b, stick_two_fire_a,
			stick_two_fire_b,
		input ready
	);

	modport sink (
		input valid, operation, tick_count, stick_one_x, stick_one_y, stick_two_x,
			stick_two_y, stick_one_fire_a, stick_one_fire_b, stick_two_fire_a,
			stick_two_fire_b,
		output ready
	);
endinterface

>>> src/gport_rsp_if.sv
interface gport_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] port_byte;

	modport source (output valid, port_byte, input ready);
	modport sink (input valid, port_byte, output ready);
endinterface

>>> src/game_port_one_shot_timers.sv
// Two-stick game port with four one-shot axis timers.
//
// Requests arrive on req (valid/ready) and carry an operation: trigger loads
// all four axis counters from the stick resistances and latches the buttons
// (stored as released = 1); tick subtracts tick_count from every counter,
// stopping at zero; read returns one port_byte on rsp (valid/ready).
// Operation code three is dropped without effect.
// Rate: one request at a time. Trigger and tick keep ready low after acceptance
// while the axis walk runs (one counter per cycle through a shared lookup/subtract
// unit); a read waits in the response state until the output register is free,
// then loads its byte there and frees the request side at the same time.
// The result sits in an output register, so new requests are taken while it
// waits; a second read stalls in the block until the first byte is taken.
// cfg_we/cfg_index/cfg_data write the stick presence bits (index 0 stick one,
// index 1 stick two); write them only while the block is idle.
// Reset clears counters, button latches and presence bits; an absent stick
// reads as ones in all four of its bits.
module game_port_one_shot_timers (
	input  logic clk,
	input  logic arst_n,
	gport_req_if.sink req,
	gport_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic cfg_data
);

	gport_pkg::req_t req_data;
	gport_pkg::cmd_t cmd;
	gport_pkg::sts_t sts;

	// Gather the request payload in axis order 1X, 1Y, 2X, 2Y
	assign req_data.tick_count = req.tick_count;
	assign req_data.res[0] = req.stick_one_x;
	assign req_data.res[1] = req.stick_one_y;
	assign req_data.res[2] = req.stick_two_x;
	assign req_data.res[3] = req.stick_two_y;
	assign req_data.fire[0] = req.stick_one_fire_a;
	assign req_data.fire[1] = req.stick_one_fire_b;
	assign req_data.fire[2] = req.stick_two_fire_a;
	assign req_data.fire[3] = req.stick_two_fire_b;

	gport_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.operation (req.operation),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gport_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_byte  (rsp.port_byte)
	);

endmodule

>>> src/gport_ctrl.sv
module gport_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic [1:0] operation,
	output logic req_ready,
	input  gport_pkg::sts_t sts,
	output gport_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_TICK = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [gport_pkg::AXIS_IDX_W-1:0] axis_q, axis_d;
	logic accept;
	logic last_axis;

	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;
	assign last_axis = (axis_q == gport_pkg::AXIS_IDX_W'(gport_pkg::AXES - 1));

	// Sequence one request: capture, walk the axes, or hand off the read byte
	always_comb begin
		state_d = state_q;
		axis_d = axis_q;
		cmd = '0;
		cmd.axis = axis_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = accept;
				if (accept) begin
					case (operation)
						gport_pkg::OP_TRIGGER: begin
							cmd.latch_buttons = 1'b1;
							state_d = S_LOAD;
						end
						gport_pkg::OP_TICK: state_d = S_TICK;
						gport_pkg::OP_READ: state_d = S_RESP;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD: begin
				cmd.load_axis = 1'b1;
				axis_d = axis_q + 1'b1;
				if (last_axis) begin
					state_d = S_IDLE;
				end
			end
			S_TICK: begin
				cmd.tick_axis = 1'b1;
				axis_d = axis_q + 1'b1;
				if (last_axis) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				axis_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= '0;
		end else begin
			state_q <= state_d;
			axis_q <= axis_d;
		end
	end

	// Axis walk always restarts from the first axis
	a_idle_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (axis_q == '0))
		else $error("axis index not cleared in idle");

	// A read request leads to the response state
	a_read_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == gport_pkg::OP_READ) |=> (state_q == S_RESP))
		else $error("read request did not reach response state");

	// Never overwrite a result still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("output register overwritten");

endmodule

>>> src/gport_dp.sv
module gport_dp (
	input  logic clk,
	input  logic arst_n,
	input  gport_pkg::req_t req,
	input  gport_pkg::cmd_t cmd,
	output gport_pkg::sts_t sts,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic cfg_data,
	input  logic out_ready,
	output logic out_valid,
	output logic [gport_pkg::BYTE_W-1:0] out_byte
);

	logic [gport_pkg::AXES-1:0][gport_pkg::RES_W-1:0] res_q;
	logic [gport_pkg::TICK_W-1:0] tick_q;
	logic [gport_pkg::CNT_W-1:0] cnt_q [gport_pkg::AXES];
	logic [gport_pkg::AXES-1:0] btn_q;
	logic present_one_q, present_two_q;
	logic [gport_pkg::BYTE_W-1:0] out_byte_q;
	logic out_valid_q;
	logic [gport_pkg::CNT_W-1:0] cnt_sel;
	logic [gport_pkg::CNT_W-1:0] cnt_ticked;
	logic [gport_pkg::BYTE_W-1:0] byte_d;

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;

	// Hold the request fields for the axis walk
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_q <= req.res;
			tick_q <= req.tick_count;
		end
	end

	// Saturating subtract of the tick count from the selected counter
	assign cnt_sel = cnt_q[cmd.axis];
	always_comb begin
		if ({1'b0, cnt_sel} < tick_q) begin
			cnt_ticked = '0;
		end else begin
			cnt_ticked = cnt_sel - tick_q[gport_pkg::CNT_W-1:0];
		end
	end

	// Load or advance one axis counter per cycle; latch released buttons
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gport_pkg::AXES; i++) begin
				cnt_q[i] <= '0;
			end
			btn_q <= '0;
		end else begin
			if (cmd.load_axis) begin
				cnt_q[cmd.axis] <= gport_pkg::PULSE_TABLE[res_q[cmd.axis]];
			end else if (cmd.tick_axis) begin
				cnt_q[cmd.axis] <= cnt_ticked;
			end
			if (cmd.latch_buttons) begin
				btn_q <= ~req.fire;
			end
		end
	end

	// Stick presence registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_one_q <= 1'b0;
			present_two_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gport_pkg::CFG_STICK_ONE_PRESENT: present_one_q <= cfg_data;
				gport_pkg::CFG_STICK_TWO_PRESENT: present_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Assemble the port byte; an absent stick reads all ones
	always_comb begin
		byte_d[0] = !present_one_q || (cnt_q[0] != '0);
		byte_d[1] = !present_one_q || (cnt_q[1] != '0);
		byte_d[2] = !present_two_q || (cnt_q[2] != '0);
		byte_d[3] = !present_two_q || (cnt_q[3] != '0);
		byte_d[4] = !present_one_q || btn_q[0];
		byte_d[5] = !present_one_q || btn_q[1];
		byte_d[6] = !present_two_q || btn_q[2];
		byte_d[7] = !present_two_q || btn_q[3];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte_q <= byte_d;
		end
	end

	// Output register valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= gport_pkg::PULSE_MAX) && (cnt_q[1] <= gport_pkg::PULSE_MAX) &&
		(cnt_q[2] <= gport_pkg::PULSE_MAX) && (cnt_q[3] <= gport_pkg::PULSE_MAX))
		else $error("axis counter above longest pulse");

	a_tick_no_rise: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_axis |=> (cnt_q[$past(cmd.axis)] <= $past(cnt_sel)))
		else $error("tick raised a counter");

endmodule

>>> test/game_port_one_shot_timers_tb.sv
`timescale 1ns / 1ps

module game_port_one_shot_timers_tb;

	// Operation code that the block drops without effect
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Marks a table row whose port byte comes from the port model
	localparam int PREDICTED = -1;
	localparam int DIR_ROWS = 24;
	// Rows before this index run with both sticks absent
	localparam int DIR_SPLIT = 3;
	localparam int PHASE_ITEMS = 340;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_PLAIN = 0;
	localparam int PHASE_HOLD = 1;
	localparam int PHASE_DRAIN = 2;

	typedef struct {
		logic [1:0] op;
		logic [gport_pkg::TICK_W-1:0] tick;
		logic [gport_pkg::RES_W-1:0] one_x;
		logic [gport_pkg::RES_W-1:0] one_y;
		logic [gport_pkg::RES_W-1:0] two_x;
		logic [gport_pkg::RES_W-1:0] two_y;
		logic [gport_pkg::AXES-1:0] fire; // 1A, 1B, 2A, 2B from bit 0 up, 1 = pressed
		int exp_port;
	} port_req_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic cfg_data;

	gport_req_if req_ch();
	gport_rsp_if rsp_ch();

	game_port_one_shot_timers u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Port model state
	logic [gport_pkg::CNT_W-1:0] axis_cnt [gport_pkg::AXES] = '{default: '0};
	logic [gport_pkg::AXES-1:0] released = '0;
	bit one_present = 1'b0;
	bit two_present = 1'b0;

	logic [gport_pkg::BYTE_W-1:0] expected_port [$];
	int mismatches = 0;
	int cycle_cnt = 0;
	bit idling = 1'b1;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;

	// Directed requests: reset state, extremes, dropped opcode, saturation
	port_req_t dir_rows [DIR_ROWS] = '{
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, 8'hFF},
		'{OP_UNUSED,             16'hFFFF,  7'd127, 7'd127, 7'd127, 7'd127, 4'b1111, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, 8'hFF},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, 8'h00},
		'{gport_pkg::OP_TRIGGER, 16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b1111, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, 8'h0F},
		'{gport_pkg::OP_TICK,    16'd345,   7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, 8'h0F},
		'{gport_pkg::OP_TICK,    16'd1,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, 8'h00},
		'{gport_pkg::OP_TRIGGER, 16'd0,     7'd127, 7'd127, 7'd127, 7'd127, 4'b0000, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, 8'hFF},
		'{gport_pkg::OP_TICK,    16'hFFFF,  7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, 8'hF0},
		'{gport_pkg::OP_TRIGGER, 16'hFFFF,  7'd100, 7'd0,   7'd127, 7'd1,   4'b0101, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_TICK,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_TICK,    16'd400,   7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{OP_UNUSED,             16'hFFFF,  7'd0,   7'd0,   7'd0,   7'd0,   4'b1111, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_TICK,    16'd20000, 7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED},
		'{gport_pkg::OP_READ,    16'd0,     7'd0,   7'd0,   7'd0,   7'd0,   4'b0000, PREDICTED}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scale a resistance code to a pulse length in counter units
	function automatic logic [gport_pkg::CNT_W-1:0] axis_pulse(
		input logic [gport_pkg::RES_W-1:0] r);
		longint unsigned v;
		v = (gport_pkg::AXIS_BASE + gport_pkg::AXIS_SLOPE * longint'(r)) *
			gport_pkg::CLOCK_NUM / gport_pkg::CLOCK_DEN;
		return v[gport_pkg::CNT_W-1:0];
	endfunction

	// Advance the port model by one request and return the byte a read sees
	function automatic logic [gport_pkg::BYTE_W-1:0] apply_request(input port_req_t it);
		logic [gport_pkg::BYTE_W-1:0] port;
		case (it.op)
			gport_pkg::OP_TRIGGER: begin
				axis_cnt[0] = axis_pulse(it.one_x);
				axis_cnt[1] = axis_pulse(it.one_y);
				axis_cnt[2] = axis_pulse(it.two_x);
				axis_cnt[3] = axis_pulse(it.two_y);
				released = ~it.fire;
			end
			gport_pkg::OP_TICK: begin
				for (int i = 0; i < gport_pkg::AXES; i++)
					axis_cnt[i] = (it.tick > axis_cnt[i]) ? '0 :
						gport_pkg::CNT_W'(axis_cnt[i] - it.tick);
			end
			default: ;
		endcase
		port = '0;
		if (one_present)
			port |= {2'b00, released[1:0], 2'b00, axis_cnt[1] != 0, axis_cnt[0] != 0};
		else
			port |= 8'h33;
		if (two_present)
			port |= {released[3:2], 2'b00, axis_cnt[3] != 0, axis_cnt[2] != 0, 2'b00};
		else
			port |= 8'hCC;
		return port;
	endfunction

	function automatic port_req_t blank_req(input logic [1:0] op);
		port_req_t it;
		it = '{op, '0, '0, '0, '0, '0, '0, PREDICTED};
		return it;
	endfunction

	// Mostly in-range resistances, now and then the codes above 100; wide uses 0 to 127
	function automatic logic [gport_pkg::RES_W-1:0] rand_res(input bit wide);
		if (wide)
			return gport_pkg::RES_W'($urandom_range(0, 127));
		return ($urandom_range(0, 9) == 0) ? gport_pkg::RES_W'($urandom_range(101, 127)) :
			gport_pkg::RES_W'($urandom_range(0, 100));
	endfunction

	// Offer one request, hold it until taken, then update the port model
	task automatic send_req(input port_req_t it);
		int gap;
		logic [gport_pkg::BYTE_W-1:0] port_exp;
		if (idling && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= it.op;
		req_ch.tick_count <= it.tick;
		req_ch.stick_one_x <= it.one_x;
		req_ch.stick_one_y <= it.one_y;
		req_ch.stick_two_x <= it.two_x;
		req_ch.stick_two_y <= it.two_y;
		req_ch.stick_one_fire_a <= it.fire[0];
		req_ch.stick_one_fire_b <= it.fire[1];
		req_ch.stick_two_fire_a <= it.fire[2];
		req_ch.stick_two_fire_b <= it.fire[3];
		do @(posedge clk); while (!req_ch.ready);
		port_exp = apply_request(it);
		if (it.op == gport_pkg::OP_READ)
			expected_port.push_back((it.exp_port == PREDICTED) ? port_exp : 8'(it.exp_port));
	endtask

	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		while (expected_port.size() != 0) @(posedge clk);
	endtask

	// Write both presence bits once the block has gone quiet
	task automatic set_presence(input bit one, input bit two);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= gport_pkg::CFG_STICK_ONE_PRESENT;
		cfg_data <= one;
		@(posedge clk);
		one_present = one;
		cfg_index <= gport_pkg::CFG_STICK_TWO_PRESENT;
		cfg_data <= two;
		@(posedge clk);
		two_present = two;
		cfg_we <= 1'b0;
	endtask

	// Trigger, then count down with reads in between; some stray requests
	task automatic run_phase(input bit one, input bit two, input int mode);
		int sent;
		int pairs;
		bit pressed;
		bit drained;
		bit saved;
		port_req_t it;
		set_presence(one, two);
		sent = 0;
		pressed = 1'b0;
		drained = 1'b0;
		while (sent < PHASE_ITEMS) begin
			if (mode == PHASE_HOLD && !pressed && sent >= 40) begin
				// Stall the result side and keep offering reads
				saved = idling;
				idling = 1'b0;
				hold_requests++;
				repeat (30) send_req(blank_req(gport_pkg::OP_READ));
				idling = saved;
				pressed = 1'b1;
				sent += 30;
			end
			if (mode == PHASE_DRAIN && !drained && sent >= PHASE_ITEMS / 2) begin
				wait_drain();
				drained = 1'b1;
			end
			if ($urandom_range(0, 99) < 85) begin
				it = blank_req(gport_pkg::OP_TRIGGER);
				it.one_x = rand_res(1'b0);
				it.one_y = rand_res(1'b0);
				it.two_x = rand_res(1'b0);
				it.two_y = rand_res(1'b0);
				it.fire = gport_pkg::AXES'($urandom_range(0, 15));
				send_req(it);
				pairs = $urandom_range(2, 12);
				repeat (pairs) begin
					it = blank_req(gport_pkg::OP_TICK);
					it.tick = ($urandom_range(0, 9) == 0) ?
						gport_pkg::TICK_W'($urandom_range(0, 15)) :
						gport_pkg::TICK_W'($urandom_range(0, 3000));
					send_req(it);
					send_req(blank_req(gport_pkg::OP_READ));
				end
				sent += 1 + 2 * pairs;
			end else begin
				it = blank_req(2'($urandom_range(0, 3)));
				it.tick = gport_pkg::TICK_W'($urandom_range(0, 65535));
				it.one_x = rand_res(1'b1);
				it.one_y = rand_res(1'b1);
				it.two_x = rand_res(1'b1);
				it.two_y = rand_res(1'b1);
				it.fire = gport_pkg::AXES'($urandom_range(0, 15));
				send_req(it);
				sent++;
			end
		end
	endtask

	// Pace the result side: random stalls, plus a long hold on demand
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (idling && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 15);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Compare each delivered byte with the oldest expected one
	always @(posedge clk) begin : check_port
		logic [gport_pkg::BYTE_W-1:0] port_exp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_port.size() == 0) begin
				$error("port_byte: expected none, got %02h", rsp_ch.port_byte);
				mismatches++;
			end else begin
				port_exp = expected_port.pop_front();
				if (rsp_ch.port_byte !== port_exp) begin
					$error("port_byte: expected %02h, got %02h", port_exp, rsp_ch.port_byte);
					mismatches++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = gport_pkg::CFG_STICK_ONE_PRESENT;
		cfg_data = 1'b0;
		rsp_ch.ready = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = gport_pkg::OP_READ;
		req_ch.tick_count = '0;
		req_ch.stick_one_x = '0;
		req_ch.stick_one_y = '0;
		req_ch.stick_two_x = '0;
		req_ch.stick_two_y = '0;
		req_ch.stick_one_fire_a = 1'b0;
		req_ch.stick_one_fire_b = 1'b0;
		req_ch.stick_two_fire_a = 1'b0;
		req_ch.stick_two_fire_b = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, first with both sticks absent, then both present
		for (int i = 0; i < DIR_SPLIT; i++)
			send_req(dir_rows[i]);
		set_presence(1'b1, 1'b1);
		for (int i = DIR_SPLIT; i < DIR_ROWS; i++)
			send_req(dir_rows[i]);

		// Random phases across every presence setting
		run_phase(1'b1, 1'b1, PHASE_PLAIN);
		run_phase(1'b0, 1'b1, PHASE_HOLD);
		run_phase(1'b1, 1'b0, PHASE_DRAIN);
		run_phase(1'b0, 1'b0, PHASE_PLAIN);
		idling = 1'b0;
		run_phase(1'b1, 1'b1, PHASE_PLAIN);

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
src/gport_pkg.sv
src/gport_req_if.sv
src/gport_rsp_if.sv
src/gport_ctrl.sv
src/gport_dp.sv
src/game_port_one_shot_timers.sv
test/game_port_one_shot_timers_tb.sv
